/* design/mot_pkg.sv */
// Package for the magnetometer offset tracker.
// Holds the field widths, register indexes, reset values and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mot_pkg;

  // Sample and fixed-point format.
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 8;

  // Datapath widths.
  localparam int OFS_W  = 28;                    // offset and reference point, Q.8
  localparam int CMP_W  = 30;                    // compensated vector
  localparam int DIF_W  = CMP_W + 1;             // change from the reference point
  localparam int MAG_W  = CMP_W;                 // magnitude of one axis
  localparam int SQ_W   = 2 * MAG_W + 2;         // sum of three squares
  localparam int ROOT_W = SQ_W / 2;              // vector length
  localparam int DLEN_W = ROOT_W + 1;            // signed length growth
  localparam int PROD_W = MAG_W + ROOT_W;        // |d| * |dlen|
  localparam int GS_W   = 3;
  localparam int DEN_W  = ROOT_W + 7;            // length shifted by the gain
  localparam int OUT_W  = 18;
  localparam int RUN_W  = 8;
  localparam int MC_W   = 18;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MC_W;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUNS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT = 2'd2;

  localparam logic [MC_W-1:0]  MIN_CHANGE_RST = 18'd40000;
  localparam logic [RUN_W-1:0] MIN_RUNS_RST   = 8'd15;
  localparam logic [GS_W-1:0]  GAIN_SHIFT_RST = 3'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_ROOT_GO,
    ST_ROOT,
    ST_PROD,
    ST_DIV_GO,
    ST_DIV,
    ST_OUT
  } mot_state_e;

endpackage
`default_nettype wire

/* design/mot_if.sv */
// Handshake interfaces for the sample, result and configuration channels.
// Depends on mot_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mot_in_if import mot_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] raw_x;
  logic signed [SAMPLE_WIDTH-1:0] raw_y;
  logic signed [SAMPLE_WIDTH-1:0] raw_z;
  logic                           cal_enable;
  modport source (output valid, raw_x, raw_y, raw_z, cal_enable, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, cal_enable, output ready);
endinterface

interface mot_out_if import mot_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] cal_x;
  logic signed [OUT_W-1:0] cal_y;
  logic signed [OUT_W-1:0] cal_z;
  logic                    offset_updated;
  modport source (output valid, cal_x, cal_y, cal_z, offset_updated, input ready);
  modport sink (input valid, cal_x, cal_y, cal_z, offset_updated, output ready);
endinterface

interface mot_cfg_if import mot_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/mot_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on mot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mot_isqrt import mot_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SQ_W-1:0]   rad_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SQ_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W+1:0]  rem_sh, trial, rem_sub;
  logic              ge;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh  = {rem_q, rad_q[SQ_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    ge      = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  // Control: counts the root bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Data: remainder, root and the radicand bits still to come.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

/* design/mot_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mot_pkg. A zero divisor gives a zero quotient.
`timescale 1ns / 1ps
`default_nettype none
module mot_div import mot_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(PROD_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] num_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              ge;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_q, num_q[PROD_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Control: counts the quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Data: the dividend register fills with quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[PROD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? '0 : num_q;

endmodule
`default_nettype wire

/* design/magnetometer_offset_tracker_unit.sv */
// Top level of the magnetometer offset tracker: sequencer, shared multiplier, state.
// Depends on mot_pkg, mot_if, mot_isqrt and mot_div.
//
//   channel  direction  contents
//   in_i     sink       raw_x, raw_y, raw_z, cal_enable
//   out_o    source     cal_x, cal_y, cal_z, offset_updated
//   cfg_i    sink       index (0 min_change, 1 min_runs, 2 gain_shift), data
//
// A sample without an offset update passes from acceptance to the next ready through
// the prepare state, six multiply and accumulate steps, the square root, the output
// state and the idle state. With an update a second length follows, then per axis
// one product step and a divide.
// Reset clears the offset, reference point, reference length and run counter.
// A new request is taken only in idle; a waiting result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_offset_tracker_unit import mot_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mot_in_if.sink    in_i,
  mot_out_if.source out_o,
  mot_cfg_if.sink   cfg_i
);

  mot_state_e state_q, state_d;

  // Configuration registers.
  logic [MC_W-1:0]  min_change_q;
  logic [RUN_W-1:0] min_runs_q;
  logic [GS_W-1:0]  gain_shift_q;

  // Tracker state.
  logic signed [OFS_W-1:0] ofs_q [3];
  logic signed [OFS_W-1:0] ref_q [3];
  logic [OFS_W-1:0]        ref_len_q;
  logic [RUN_W-1:0]        run_q;

  // Working registers for one request.
  logic signed [SAMPLE_WIDTH-1:0] raw_q [3];
  logic                           cal_en_q;
  logic signed [CMP_W-1:0]        comp_q [3];
  logic signed [DIF_W-1:0]        d_q [3];
  logic [SQ_W-1:0]                acc_q;
  logic [PROD_W-1:0]              prod_q;
  logic [ROOT_W-1:0]              dist_q;
  logic signed [DLEN_W-1:0]       dlen_q;
  logic [1:0]                     ax_q;
  logic                           pass_q;
  logic                           upd_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] cal_q [3];
  logic                    out_upd_q;

  // Sequencer outputs.
  logic in_ready, mul_en, root_go, div_go, out_load;

  // Shared units.
  logic              root_done, div_done;
  logic [ROOT_W-1:0] root;
  logic [PROD_W-1:0] quot;
  logic [DEN_W-1:0]  den;
  logic [MAG_W-1:0]  mul_a;
  logic [ROOT_W-1:0] mul_b;

  // Per-axis combinational values.
  logic signed [CMP_W-1:0]  comp_n [3];
  logic [MAG_W-1:0]         cmag [3];
  logic [MAG_W-1:0]         dmag [3];
  logic signed [OFS_W:0]    osum [3];
  logic signed [OUT_W+2:0]  ofloor [3];
  logic signed [OUT_W-1:0]  cal_n [3];
  logic signed [CMP_W-1:0]  ref_n [3];
  logic [DIF_W-1:0]         dneg [3];
  logic [CMP_W-1:0]         cneg [3];

  logic [DLEN_W-1:0]        dlen_neg;
  logic [ROOT_W-1:0]        dlen_mag;
  logic                     big;
  logic [RUN_W-1:0]         run_n;
  logic                     trig;
  logic [MAG_W-1:0]         qc;
  logic                     est_neg;
  logic signed [31:0]       ofs_ext, qc_ext, ofs_sum;
  logic signed [OFS_W-1:0]  ofs_new;

  // Per-axis arithmetic: compensated vector, change, magnitudes and the result.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp_n[i] = CMP_W'(signed'({raw_q[i], {FRAC_BITS{1'b0}}})) + CMP_W'(ofs_q[i]);
      dneg[i]   = -d_q[i];
      cneg[i]   = -comp_q[i];
      dmag[i]   = d_q[i][DIF_W-1] ? dneg[i][MAG_W-1:0] : d_q[i][MAG_W-1:0];
      cmag[i]   = comp_q[i][CMP_W-1] ? cneg[i] : comp_q[i];
      osum[i]   = (OFS_W+1)'(signed'({raw_q[i], {FRAC_BITS{1'b0}}}))
                  + (OFS_W+1)'(ofs_q[i]);
      ofloor[i] = osum[i][OFS_W:FRAC_BITS];
      if (ofloor[i] > (OUT_W+3)'(2**(OUT_W-1) - 1)) begin
        cal_n[i] = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (ofloor[i] < -(OUT_W+3)'(2**(OUT_W-1))) begin
        cal_n[i] = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        cal_n[i] = ofloor[i][OUT_W-1:0];
      end
      if (comp_q[i] > CMP_W'(2**(OFS_W-1) - 1)) begin
        ref_n[i] = CMP_W'(2**(OFS_W-1) - 1);
      end else if (comp_q[i] < -CMP_W'(2**(OFS_W-1))) begin
        ref_n[i] = -CMP_W'(2**(OFS_W-1));
      end else begin
        ref_n[i] = comp_q[i];
      end
    end
  end

  // Run counter and update decision from the distance.
  always_comb begin
    big = root[ROOT_W-1:FRAC_BITS] > {{(ROOT_W-FRAC_BITS-MC_W){1'b0}}, min_change_q};
    if (!big) begin
      run_n = '0;
    end else if (run_q == {RUN_W{1'b1}}) begin
      run_n = run_q;
    end else begin
      run_n = run_q + 1'b1;
    end
    trig = (run_n > min_runs_q) && cal_en_q;
  end

  // Correction of one axis from the quotient.
  always_comb begin
    dlen_neg = -dlen_q;
    dlen_mag = dlen_q[DLEN_W-1] ? dlen_neg[ROOT_W-1:0] : dlen_q[ROOT_W-1:0];
    den      = {{(DEN_W-ROOT_W){1'b0}}, dist_q} << gain_shift_q;
    qc       = (|quot[PROD_W-1:MAG_W-1]) ? {1'b1, {(MAG_W-1){1'b0}}}
                                          : {1'b0, quot[MAG_W-2:0]};
    est_neg  = d_q[ax_q][DIF_W-1] != dlen_q[DLEN_W-1];
    ofs_ext  = 32'(ofs_q[ax_q]);
    qc_ext   = signed'({2'b00, qc});
    ofs_sum  = est_neg ? (ofs_ext + qc_ext) : (ofs_ext - qc_ext);
    if (ofs_sum > 32'sd134217727) begin
      ofs_new = {1'b0, {(OFS_W-1){1'b1}}};
    end else if (ofs_sum < -32'sd134217728) begin
      ofs_new = {1'b1, {(OFS_W-1){1'b0}}};
    end else begin
      ofs_new = ofs_sum[OFS_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_i.valid) state_d = ST_PREP;
      ST_PREP:    state_d = ST_MUL;
      ST_MUL:     state_d = ST_ACC;
      ST_ACC:     state_d = (ax_q == 2'd2) ? ST_ROOT_GO : ST_MUL;
      ST_ROOT_GO: state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          if (pass_q) state_d = ST_PROD;
          else        state_d = trig ? ST_MUL : ST_OUT;
        end
      end
      ST_PROD:    state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = (ax_q == 2'd2) ? ST_OUT : ST_PROD;
      end
      ST_OUT:     if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and multiplier operands.
  always_comb begin
    in_ready = 1'b0;
    mul_en   = 1'b0;
    root_go  = 1'b0;
    div_go   = 1'b0;
    out_load = 1'b0;
    mul_a    = pass_q ? cmag[ax_q] : dmag[ax_q];
    mul_b    = {1'b0, mul_a};
    case (state_q)
      ST_IDLE:    in_ready = 1'b1;
      ST_MUL:     mul_en   = 1'b1;
      ST_ROOT_GO: root_go  = 1'b1;
      ST_PROD: begin
        mul_en = 1'b1;
        mul_a  = dmag[ax_q];
        mul_b  = dlen_mag;
      end
      ST_DIV_GO:  div_go   = 1'b1;
      ST_OUT:     out_load = !out_valid_q || out_o.ready;
      default:    in_ready = 1'b0;
    endcase
  end

  // Sequencer state and tracker state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      run_q     <= '0;
      ref_len_q <= '0;
      for (int i = 0; i < 3; i++) begin
        ofs_q[i] <= '0;
        ref_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_ROOT && root_done) begin
        if (!pass_q) begin
          run_q <= trig ? '0 : run_n;
        end else begin
          ref_len_q <= (|root[ROOT_W-1:OFS_W]) ? {OFS_W{1'b1}} : root[OFS_W-1:0];
          for (int i = 0; i < 3; i++) ref_q[i] <= ref_n[i][OFS_W-1:0];
        end
      end
      if (state_q == ST_DIV && div_done) ofs_q[ax_q] <= ofs_new;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          raw_q[0] <= in_i.raw_x;
          raw_q[1] <= in_i.raw_y;
          raw_q[2] <= in_i.raw_z;
          cal_en_q <= in_i.cal_enable;
        end
      end
      ST_PREP: begin
        for (int i = 0; i < 3; i++) begin
          comp_q[i] <= comp_n[i];
          d_q[i]    <= DIF_W'(comp_n[i]) - DIF_W'(ref_q[i]);
        end
        acc_q  <= '0;
        ax_q   <= '0;
        pass_q <= 1'b0;
        upd_q  <= 1'b0;
      end
      ST_ACC: begin
        acc_q <= acc_q + {1'b0, prod_q};
        if (ax_q != 2'd2) ax_q <= ax_q + 1'b1;
      end
      ST_ROOT: begin
        if (root_done) begin
          ax_q <= '0;
          if (!pass_q) begin
            dist_q <= root;
            if (trig) begin
              pass_q <= 1'b1;
              acc_q  <= '0;
              upd_q  <= 1'b1;
            end
          end else begin
            dlen_q <= signed'({1'b0, root}) - signed'({{(DLEN_W-OFS_W){1'b0}}, ref_len_q});
          end
        end
      end
      ST_DIV: begin
        if (div_done && ax_q != 2'd2) ax_q <= ax_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_change_q <= MIN_CHANGE_RST;
      min_runs_q   <= MIN_RUNS_RST;
      gain_shift_q <= GAIN_SHIFT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MIN_CHANGE: min_change_q <= cfg_i.data[MC_W-1:0];
        REG_MIN_RUNS:   min_runs_q   <= cfg_i.data[RUN_W-1:0];
        REG_GAIN_SHIFT: gain_shift_q <= cfg_i.data[GS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) cal_q[i] <= cal_n[i];
      out_upd_q <= upd_q;
    end
  end

  mot_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_go),
    .rad_i   (acc_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  mot_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (prod_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign in_i.ready           = in_ready;
  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = out_valid_q;
  assign out_o.cal_x          = cal_q[0];
  assign out_o.cal_y          = cal_q[1];
  assign out_o.cal_z          = cal_q[2];
  assign out_o.offset_updated = out_upd_q;

endmodule
`default_nettype wire
